@@ rtl/vcrp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcrp_pkg
// Shared types and codes for the video chip register port.
// ----------------------------------------------------------------------------
package vcrp_pkg;

    // Transaction kinds
    localparam logic [2:0] KIND_READ      = 3'd0;
    localparam logic [2:0] KIND_WRITE     = 3'd1;
    localparam logic [2:0] KIND_PEEK      = 3'd2;
    localparam logic [2:0] KIND_VBLANK    = 3'd3;
    localparam logic [2:0] KIND_FRAME     = 3'd4;
    localparam logic [2:0] KIND_SPR0_HIT  = 3'd5;

    // Chip register indexes
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OBJ_ADDR = 3'd3;
    localparam logic [2:0] REG_OBJ_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // Mirroring modes
    localparam logic [1:0] MIRROR_VERT   = 2'd0;
    localparam logic [1:0] MIRROR_HORZ   = 2'd1;
    localparam logic [1:0] MIRROR_LOW    = 2'd2;
    localparam logic [1:0] MIRROR_HIGH   = 2'd3;

    // Upper address bits of the palette window
    localparam logic [5:0] PALETTE_PAGE = 6'h3F;

    // Video bus regions
    typedef enum logic [1:0] {
        REGION_PATTERN,
        REGION_NAME,
        REGION_PALETTE
    } region_t;

    // Source of the returned byte
    typedef enum logic [1:0] {
        RD_CONST,
        RD_OBJ,
        RD_VMEM
    } rd_sel_t;

    // One video memory access
    typedef struct packed {
        logic        en;
        logic        we;
        logic [13:0] addr;
        logic [7:0]  wdata;
    } vmem_req_t;

endpackage

@@ rtl/vcrp_vmem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcrp_vmem
// Pattern, nametable and palette memories behind the 14-bit video bus.
// ----------------------------------------------------------------------------
module vcrp_vmem
(
    input  logic               clk,
    input  vcrp_pkg::vmem_req_t req,
    input  logic [1:0]         mirroring_mode,
    output logic [7:0]         rdata
);

    logic [7:0] pattern_mem [8192];
    logic [7:0] name_mem    [2048];
    logic [5:0] palette_mem [32];

    vcrp_pkg::region_t region;
    vcrp_pkg::region_t region_reg;
    logic [10:0] name_idx;
    logic [4:0]  pal_idx;
    logic        name_table;
    logic [7:0]  pattern_rd_reg;
    logic [7:0]  name_rd_reg;
    logic [5:0]  palette_rd_reg;

    // Decode region and fold nametable quarters / palette mirrors
    always_comb
    begin
        if (!req.addr[13])
            region = vcrp_pkg::REGION_PATTERN;
        else if (req.addr[13:8] == vcrp_pkg::PALETTE_PAGE)
            region = vcrp_pkg::REGION_PALETTE;
        else
            region = vcrp_pkg::REGION_NAME;

        case (mirroring_mode)
            vcrp_pkg::MIRROR_VERT: name_table = req.addr[10];
            vcrp_pkg::MIRROR_HORZ: name_table = req.addr[11];
            vcrp_pkg::MIRROR_LOW:  name_table = 1'b0;
            default:               name_table = 1'b1;
        endcase
        name_idx = {name_table, req.addr[9:0]};

        pal_idx = req.addr[4:0];
        if (pal_idx[4] && (pal_idx[1:0] == 2'b00))
            pal_idx[4] = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req.en && req.we && (region == vcrp_pkg::REGION_PATTERN))
            pattern_mem[req.addr[12:0]] <= req.wdata;
        if (req.en && !req.we)
            pattern_rd_reg <= pattern_mem[req.addr[12:0]];
    end

    always_ff @(posedge clk)
    begin
        if (req.en && req.we && (region == vcrp_pkg::REGION_NAME))
            name_mem[name_idx] <= req.wdata;
        if (req.en && !req.we)
            name_rd_reg <= name_mem[name_idx];
    end

    always_ff @(posedge clk)
    begin
        if (req.en && req.we && (region == vcrp_pkg::REGION_PALETTE))
            palette_mem[pal_idx] <= req.wdata[5:0];
        if (req.en && !req.we)
            palette_rd_reg <= palette_mem[pal_idx];
    end

    // Remember which memory answers the pending read
    always_ff @(posedge clk)
    begin
        if (req.en && !req.we)
            region_reg <= region;
    end

    always_comb
    begin
        case (region_reg)
            vcrp_pkg::REGION_PATTERN: rdata = pattern_rd_reg;
            vcrp_pkg::REGION_NAME:    rdata = name_rd_reg;
            default:                  rdata = {2'b00, palette_rd_reg};
        endcase
    end

endmodule

@@ rtl/video_chip_register_port.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_chip_register_port
// Processor-side register port of a tile video chip with its video memories.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle while in_stall is low and returns
// one result for each through the second-stage and output registers. Every
// transaction updates the register file in the cycle it is accepted and
// issues at most one access to the object memory or the video memories;
// both have a registered synchronous read, and the returned byte is joined
// with the register snapshot in the second stage, then held in the output
// register. The buffered data port forwards the byte arriving from video
// memory to the very next transaction, so back-to-back data or status reads
// see the updated read buffer without a bubble. A result waiting in the
// output register blocks the next input transaction only when stage two
// is also full. Mirroring is written through the configuration channel,
// which is always ready and must only be written while the block is idle.
// Memory contents are undefined until written.
// ----------------------------------------------------------------------------
module video_chip_register_port
(
    input  logic       clk,
    input  logic       rst_n,

    // configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] mirroring_mode,

    // input transactions
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] kind,
    input  logic [2:0] register_index,
    input  logic [7:0] write_data,

    // results
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        nmi_pulse,
    output logic [15:0] video_address,
    output logic [2:0]  fine_scroll_x,
    output logic [7:0]  control_value,
    output logic [7:0]  mask_value
);

    // ---------------- register file ----------------
    logic [1:0]  mirror_reg;
    logic [7:0]  control_reg,  control_next;
    logic [7:0]  mask_reg,     mask_next;
    logic [2:0]  status_reg,   status_next;     // status bits 7..5
    logic        toggle_reg,   toggle_next;
    logic [2:0]  fine_x_reg,   fine_x_next;
    logic [15:0] temp_reg,     temp_next;
    logic [15:0] cur_reg,      cur_next;
    logic [7:0]  obj_ptr_reg,  obj_ptr_next;
    logic [7:0]  read_buffer_reg;

    // ---------------- second stage ----------------
    logic              b_valid_reg;
    vcrp_pkg::rd_sel_t b_sel_reg;
    logic [7:0]        b_rd_reg;
    logic              b_nmi_reg;
    logic              b_bufload_reg;
    logic [15:0]       b_vaddr_reg;
    logic [2:0]        b_fine_x_reg;
    logic [7:0]        b_control_reg;
    logic [7:0]        b_mask_reg;

    // ---------------- output stage ----------------
    logic        out_valid_reg;
    logic [7:0]  out_rd_reg;
    logic        out_nmi_reg;
    logic [15:0] out_vaddr_reg;
    logic [2:0]  out_fine_x_reg;
    logic [7:0]  out_control_reg;
    logic [7:0]  out_mask_reg;

    // ---------------- first stage decode ----------------
    logic              accept;
    logic              b_move;
    logic              out_free;
    logic [7:0]        rb_fwd;
    logic [7:0]        rd_next;
    logic              nmi_next;
    logic              bufload_next;
    vcrp_pkg::rd_sel_t sel_next;
    logic [15:0]       step;
    logic              obj_we;
    logic [7:0]        obj_mem [256];
    logic [7:0]        obj_rd_reg;
    logic [7:0]        vmem_rdata;
    logic [7:0]        b_rd_final;
    vcrp_pkg::vmem_req_t vreq;

    // Output register frees when empty or taken; stage two moves into it.
    assign out_free  = !out_valid_reg || !out_stall;
    assign b_move    = b_valid_reg && out_free;
    assign in_stall  = b_valid_reg && !out_free;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Forward the byte that the previous data read is loading into the buffer
    assign rb_fwd = (b_valid_reg && b_bufload_reg) ? vmem_rdata : read_buffer_reg;
    assign step   = control_reg[2] ? 16'd32 : 16'd1;

    always_comb
    begin
        control_next = control_reg;
        mask_next    = mask_reg;
        status_next  = status_reg;
        toggle_next  = toggle_reg;
        fine_x_next  = fine_x_reg;
        temp_next    = temp_reg;
        cur_next     = cur_reg;
        obj_ptr_next = obj_ptr_reg;
        rd_next      = 8'h00;
        nmi_next     = 1'b0;
        bufload_next = 1'b0;
        sel_next     = vcrp_pkg::RD_CONST;
        obj_we       = 1'b0;
        vreq.en      = 1'b0;
        vreq.we      = 1'b0;
        vreq.addr    = cur_reg[13:0];
        vreq.wdata   = write_data;

        case (kind)
            vcrp_pkg::KIND_READ:
            begin
                case (register_index)
                    vcrp_pkg::REG_STATUS:
                    begin
                        rd_next        = {status_reg, rb_fwd[4:0]};
                        status_next[2] = 1'b0;
                        toggle_next    = 1'b0;
                    end
                    vcrp_pkg::REG_OBJ_DATA:
                    begin
                        sel_next = vcrp_pkg::RD_OBJ;
                    end
                    vcrp_pkg::REG_DATA:
                    begin
                        // palette reads bypass the buffer
                        rd_next      = rb_fwd;
                        vreq.en      = 1'b1;
                        bufload_next = 1'b1;
                        if (cur_reg[13:8] == vcrp_pkg::PALETTE_PAGE)
                            sel_next = vcrp_pkg::RD_VMEM;
                        cur_next = cur_reg + step;
                    end
                    default:
                    begin
                    end
                endcase
            end

            vcrp_pkg::KIND_WRITE:
            begin
                case (register_index)
                    vcrp_pkg::REG_CTRL:
                    begin
                        control_next     = write_data;
                        temp_next[11:10] = write_data[1:0];
                        nmi_next = !control_reg[7] && write_data[7] && status_reg[2];
                    end
                    vcrp_pkg::REG_MASK:
                    begin
                        mask_next = write_data;
                    end
                    vcrp_pkg::REG_OBJ_ADDR:
                    begin
                        obj_ptr_next = write_data;
                    end
                    vcrp_pkg::REG_OBJ_DATA:
                    begin
                        obj_we       = 1'b1;
                        obj_ptr_next = obj_ptr_reg + 8'd1;
                    end
                    vcrp_pkg::REG_SCROLL:
                    begin
                        if (!toggle_reg)
                        begin
                            fine_x_next    = write_data[2:0];
                            temp_next[4:0] = write_data[7:3];
                            toggle_next    = 1'b1;
                        end
                        else
                        begin
                            temp_next[14:12] = write_data[2:0];
                            temp_next[9:5]   = write_data[7:3];
                            toggle_next      = 1'b0;
                        end
                    end
                    vcrp_pkg::REG_ADDR:
                    begin
                        if (!toggle_reg)
                        begin
                            temp_next   = {2'b00, write_data[5:0], temp_reg[7:0]};
                            toggle_next = 1'b1;
                        end
                        else
                        begin
                            temp_next   = {temp_reg[15:8], write_data};
                            cur_next    = {temp_reg[15:8], write_data};
                            toggle_next = 1'b0;
                        end
                    end
                    vcrp_pkg::REG_DATA:
                    begin
                        vreq.en  = 1'b1;
                        vreq.we  = 1'b1;
                        cur_next = cur_reg + step;
                    end
                    default:
                    begin
                    end
                endcase
            end

            vcrp_pkg::KIND_PEEK:
            begin
                case (register_index)
                    vcrp_pkg::REG_CTRL:   rd_next = control_reg;
                    vcrp_pkg::REG_MASK:   rd_next = mask_reg;
                    vcrp_pkg::REG_STATUS: rd_next = {status_reg, 5'b00000};
                    default:              rd_next = 8'h00;
                endcase
            end

            vcrp_pkg::KIND_VBLANK:
            begin
                status_next[2] = 1'b1;
                nmi_next       = control_reg[7];
            end

            vcrp_pkg::KIND_FRAME:
            begin
                status_next = 3'b000;
            end

            vcrp_pkg::KIND_SPR0_HIT:
            begin
                status_next[1] = 1'b1;
            end

            default:
            begin
            end
        endcase

        // only touch memory for an accepted transaction
        vreq.en = vreq.en && accept;
        obj_we  = obj_we && accept;
    end

    // ---------------- object memory ----------------
    always_ff @(posedge clk)
    begin
        if (obj_we)
            obj_mem[obj_ptr_reg] <= write_data;
        if (accept && (sel_next == vcrp_pkg::RD_OBJ))
            obj_rd_reg <= obj_mem[obj_ptr_reg];
    end

    // ---------------- video memories ----------------
    vcrp_vmem u_vmem
    (
        .clk            (clk),
        .req            (vreq),
        .mirroring_mode (mirror_reg),
        .rdata          (vmem_rdata)
    );

    // ---------------- register file update ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg  <= vcrp_pkg::MIRROR_VERT;
            control_reg <= 8'h00;
            mask_reg    <= 8'h00;
            status_reg  <= 3'b000;
            toggle_reg  <= 1'b0;
            fine_x_reg  <= 3'd0;
            temp_reg    <= 16'h0000;
            cur_reg     <= 16'h0000;
            obj_ptr_reg <= 8'h00;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mirror_reg <= mirroring_mode;
            if (accept)
            begin
                control_reg <= control_next;
                mask_reg    <= mask_next;
                status_reg  <= status_next;
                toggle_reg  <= toggle_next;
                fine_x_reg  <= fine_x_next;
                temp_reg    <= temp_next;
                cur_reg     <= cur_next;
                obj_ptr_reg <= obj_ptr_next;
            end
        end
    end

    // Load the read buffer as the data read leaves stage two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            read_buffer_reg <= 8'h00;
        else if (b_move && b_bufload_reg)
            read_buffer_reg <= vmem_rdata;
    end

    // ---------------- stage two ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (accept)
            b_valid_reg <= 1'b1;
        else if (b_move)
            b_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_sel_reg     <= sel_next;
            b_rd_reg      <= rd_next;
            b_nmi_reg     <= nmi_next;
            b_bufload_reg <= bufload_next;
            b_vaddr_reg   <= cur_next;
            b_fine_x_reg  <= fine_x_next;
            b_control_reg <= control_next;
            b_mask_reg    <= mask_next;
        end
    end

    always_comb
    begin
        case (b_sel_reg)
            vcrp_pkg::RD_OBJ:  b_rd_final = obj_rd_reg;
            vcrp_pkg::RD_VMEM: b_rd_final = vmem_rdata;
            default:           b_rd_final = b_rd_reg;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_move)
        begin
            out_rd_reg      <= b_rd_final;
            out_nmi_reg     <= b_nmi_reg;
            out_vaddr_reg   <= b_vaddr_reg;
            out_fine_x_reg  <= b_fine_x_reg;
            out_control_reg <= b_control_reg;
            out_mask_reg    <= b_mask_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = out_rd_reg;
    assign nmi_pulse     = out_nmi_reg;
    assign video_address = out_vaddr_reg;
    assign fine_scroll_x = out_fine_x_reg;
    assign control_value = out_control_reg;
    assign mask_value    = out_mask_reg;

endmodule
